// File: sv/tdt_pkg.sv
// tdt_pkg: shared types and constants for the tap / double-tap detector
// used by tdt_scan and tap_double_tap_detector_unit; no dependencies
package tdt_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] RES_NONE   = 2'd0;
    localparam logic [1:0] RES_SINGLE = 2'd1;
    localparam logic [1:0] RES_DOUBLE = 2'd2;

    localparam logic CFG_TAP_THRESHOLD = 1'b0;
    localparam logic CFG_DT_TIMEOUT    = 1'b1;

    localparam logic [15:0] THRESHOLD_RST = 16'd25;
    localparam logic [15:0] TIMEOUT_RST   = 16'd100;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic first;
        logic step;
    } scan_ctl_t;

endpackage

// File: sv/tdt_cell.sv
// tdt_cell: one window entry; takes its neighbor's value when shifting
// depends on nothing beyond the clock and reset
module tdt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  logic signed [15:0] din,
    output logic signed [15:0] dout
);

    logic signed [15:0] y_reg;
    logic signed [15:0] y_next;

    always_comb begin
        y_next = shift_en ? din : y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg <= '0;
        end else begin
            y_reg <= y_next;
        end
    end

    assign dout = y_reg;

endmodule

// File: sv/tdt_scan.sv
// tdt_scan: running max / min over the entries leaving the head of the window
// and the tap decision; uses tdt_pkg
module tdt_scan (
    input  logic               aclk,
    input  tdt_pkg::scan_ctl_t ctl,
    input  logic signed [15:0] head,
    input  logic [15:0]        threshold,
    output logic               tap
);

    logic signed [15:0] hi_reg;
    logic signed [15:0] hi_next;
    logic signed [15:0] lo_reg;
    logic signed [15:0] lo_next;
    logic signed [16:0] hi_ext;
    logic signed [16:0] lo_ext;
    logic [16:0]        abs_hi;
    logic [16:0]        abs_lo;
    logic signed [17:0] diff;

    always_comb begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctl.first) begin
            hi_next = head;
            lo_next = head;
        end else if (ctl.step) begin
            if (head > hi_reg) begin
                hi_next = head;
            end
            if (head < lo_reg) begin
                lo_next = head;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    // exact |max| - |min| in 18 bits
    always_comb begin
        hi_ext = {hi_reg[15], hi_reg};
        lo_ext = {lo_reg[15], lo_reg};
        abs_hi = hi_ext[16] ? 17'(-hi_ext) : 17'(hi_ext);
        abs_lo = lo_ext[16] ? 17'(-lo_ext) : 17'(lo_ext);
        diff   = $signed({1'b0, abs_hi}) - $signed({1'b0, abs_lo});
        tap    = diff > $signed({2'b00, threshold});
    end

endmodule

// File: sv/tap_double_tap_detector_unit.sv
// tap_double_tap_detector_unit: top level of the tap / double-tap detector
// instantiates tdt_cell and tdt_scan; uses tdt_pkg
//
// A sample beat with any axis-ready bit set shifts its Y value into a ten-entry
// window held in a row of cells. The window is then rotated once around the
// row, one entry per cycle, while a scan unit keeps the maximum and minimum;
// a decide state then makes the tap decision and loads the result register
// once the result register is free. A timer tick gives no result. A new beat
// is accepted while a finished result still waits on the result channel.
module tap_double_tap_detector_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_axis_ready,
    input  logic signed [15:0] s_accel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_tap_result
);

    localparam int D = tdt_pkg::WINDOW_DEPTH;

    tdt_pkg::state_t              state_reg;
    tdt_pkg::state_t              state_next;
    logic [tdt_pkg::CNT_W-1:0]    cnt_reg;
    logic [tdt_pkg::CNT_W-1:0]    cnt_next;
    logic [15:0]                  thr_reg;
    logic [15:0]                  tmo_reg;
    logic [1:0]                   pend_reg;
    logic [1:0]                   pend_next;
    logic [15:0]                  tick_reg;
    logic [15:0]                  tick_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [1:0]                   res_reg;
    logic [1:0]                   res_next;

    logic                         accept;
    logic                         shift_en;
    logic                         out_free;
    logic                         tap;
    logic [1:0]                   pend_inc;
    logic signed [15:0]           tail_din;
    logic signed [15:0]           cell_y [D];
    tdt_pkg::scan_ctl_t           scan_ctl;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tdt_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_tap_result = res_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tdt_pkg::THRESHOLD_RST;
            tmo_reg <= tdt_pkg::TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == tdt_pkg::CFG_TAP_THRESHOLD) begin
                thr_reg <= cfg_wr_data;
            end else begin
                thr_reg <= thr_reg;
            end
            if (cfg_addr == tdt_pkg::CFG_DT_TIMEOUT) begin
                tmo_reg <= cfg_wr_data;
            end else begin
                tmo_reg <= tmo_reg;
            end
        end
    end

    // window: new sample enters the tail, during the scan the head wraps around
    assign shift_en = (accept && s_opcode == tdt_pkg::OP_SAMPLE && s_axis_ready != 4'd0)
                      || (state_reg == tdt_pkg::ST_SCAN);
    assign tail_din = (state_reg == tdt_pkg::ST_SCAN) ? cell_y[0] : s_accel_y;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            if (gi == D - 1) begin : g_tail
                tdt_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .din      (tail_din),
                    .dout     (cell_y[gi])
                );
            end else begin : g_body
                tdt_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .din      (cell_y[gi+1]),
                    .dout     (cell_y[gi])
                );
            end
        end
    endgenerate

    assign scan_ctl.first = (state_reg == tdt_pkg::ST_SCAN) && (cnt_reg == '0);
    assign scan_ctl.step  = (state_reg == tdt_pkg::ST_SCAN);

    tdt_scan u_scan (
        .aclk      (aclk),
        .ctl       (scan_ctl),
        .head      (cell_y[0]),
        .threshold (thr_reg),
        .tap       (tap)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdt_pkg::ST_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 2'd0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        tick_next    = tick_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pend_inc     = pend_reg + 2'd1;
        case (state_reg)
            tdt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == tdt_pkg::OP_TICK) begin
                        if (tick_reg != tdt_pkg::TICK_MAX) begin
                            tick_next = tick_reg + 16'd1;
                        end
                    end else begin
                        cnt_next   = '0;
                        state_next = tdt_pkg::ST_SCAN;
                    end
                end
            end
            tdt_pkg::ST_SCAN: begin
                if (cnt_reg == tdt_pkg::CNT_W'(D - 1)) begin
                    state_next = tdt_pkg::ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + tdt_pkg::CNT_W'(1);
                end
            end
            tdt_pkg::ST_DECIDE: begin
                if (out_free) begin
                    res_next     = tdt_pkg::RES_NONE;
                    m_valid_next = 1'b1;
                    state_next   = tdt_pkg::ST_IDLE;
                    if (tap) begin
                        pend_next = pend_inc;
                        if (pend_inc == 2'd1) begin
                            tick_next = '0;
                        end else if (pend_inc == 2'd2) begin
                            tick_next = '0;
                            pend_next = 2'd0;
                            res_next  = tdt_pkg::RES_DOUBLE;
                        end
                    end else if (pend_reg == 2'd1 && tick_reg > tmo_reg) begin
                        tick_next = '0;
                        pend_next = 2'd0;
                        res_next  = tdt_pkg::RES_SINGLE;
                    end
                end
            end
            default: begin
                state_next = tdt_pkg::ST_IDLE;
            end
        endcase
    end

    // pending count only ever holds zero or one
    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd2 && pend_reg != 2'd3)
        else $error("pending tap count out of range");

    a_tick_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == tdt_pkg::OP_TICK && tick_reg != tdt_pkg::TICK_MAX)
        |=> tick_reg == $past(tick_reg) + 16'd1)
        else $error("tick beat did not advance the counter");

    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdt_pkg::ST_SCAN && cnt_reg == tdt_pkg::CNT_W'(D - 1))
        |=> state_reg == tdt_pkg::ST_DECIDE)
        else $error("scan did not end after a full rotation");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == tdt_pkg::ST_DECIDE)
        else $error("result raised outside the decision step");

endmodule
